/* rtl/lbs_pkg.sv */
package lbs_pkg;

    localparam int QUEUE_DEPTH = 6;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QSUM_W = QCNT_W + 1;

    localparam logic [15:0] INITIAL_OFF_RESET = 16'd100;
    localparam logic [15:0] REPEAT_GAP_RESET = 16'd200;
    localparam logic [15:0] INTERVAL_RESET = 16'd0;

    typedef enum logic [1:0] {
        REG_INITIAL_OFF = 2'd0,
        REG_REPEAT_GAP = 2'd1,
        REG_INTERVAL = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_COMMAND = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INIT,
        PH_ON,
        PH_OFF,
        PH_GAP,
        PH_INTERVAL
    } run_phase_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    typedef struct packed {
        logic       persistent;
        logic [7:0] repeat_count;
        logic [1:0] pattern_len;
        logic [15:0] off_time_ms;
        logic [15:0] on_time_ms;
        color_t     color;
    } queue_entry_t;

    typedef struct packed {
        logic [4:0] pad;
        queue_entry_t entry;
    } in_word_t;

    typedef struct packed {
        logic [4:0] pad;
        logic       busy_res;
        logic       item_done;
        logic       accepted;
        color_t     led;
    } out_word_t;

endpackage

/* rtl/led_blink_sequencer.sv */
// Blink sequencer for one RGB LED. Each input word is either a one-millisecond tick
// (s_tuser = 0) or a blink command (s_tuser = 1); every accepted word yields exactly one
// result word carrying the LED color after that word, the queued/dropped flag for commands,
// the done pulse and the busy flag. Commands wait in a six-entry queue held in a
// synchronous memory whose head entry is read ahead of time, so a tick can start the next
// command at once. It takes one word per clock while its skid register is empty; the
// result of a word is registered at the edge that accepts it, in the output register or,
// while that holds an unsent result, in the skid register. This two-word buffer lets it
// accept one more word while a result waits. Configuration writes through cfg_we, cfg_addr
// and cfg_wdata take effect on the next clock and are meant to be issued only while idle.
module led_blink_sequencer import lbs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // red, green, blue, on_time_ms, off_time_ms, pattern_len,
    // repeat_count, persistent, zero fill
    input  logic [71:0] s_tdata,
    // req_type
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // led_red, led_green, led_blue, accepted, item_done, busy_res, zero fill
    output logic [31:0] m_tdata
);

    logic [15:0] initial_off_reg;
    logic [15:0] repeat_gap_reg;
    logic [15:0] interval_reg;

    queue_entry_t mem [QUEUE_DEPTH];
    queue_entry_t rd_data_reg;
    logic [QPTR_W-1:0] wr_addr;
    logic wr_en;

    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    run_phase_t phase_reg, phase_next;
    logic [15:0] time_left_reg, time_left_next;
    logic [7:0] repeat_idx_reg, repeat_idx_next;
    logic [7:0] repeat_inc;
    queue_entry_t active_reg, active_next;
    color_t held_reg, held_next;
    color_t shown_reg, shown_next;

    logic acc;
    logic accepted;
    logic item_done;
    logic do_finish;
    logic [QSUM_W-1:0] slot_sum;
    in_word_t in_word;
    out_word_t result;

    out_word_t out_data_reg, skid_data_reg;
    logic out_valid_reg, skid_valid_reg;
    logic pop;

    assign in_word = in_word_t'(s_tdata);
    assign s_tready = !skid_valid_reg;
    assign acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_off_reg <= INITIAL_OFF_RESET;
            repeat_gap_reg <= REPEAT_GAP_RESET;
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_INITIAL_OFF: initial_off_reg <= cfg_wdata;
                REG_REPEAT_GAP: repeat_gap_reg <= cfg_wdata;
                REG_INTERVAL: interval_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        slot_sum = QSUM_W'(head_reg) + QSUM_W'(count_reg);
        if (slot_sum >= QSUM_W'(QUEUE_DEPTH)) begin
            slot_sum = slot_sum - QSUM_W'(QUEUE_DEPTH);
        end
        wr_addr = slot_sum[QPTR_W-1:0];
    end

    // The read port always fetches the entry that will be at the head next cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_word.entry;
        end
        if (wr_en && wr_addr == head_next) begin
            rd_data_reg <= in_word.entry;
        end else begin
            rd_data_reg <= mem[head_next];
        end
    end

    assign repeat_inc = repeat_idx_reg + 8'd1;

    always_comb begin
        head_next = head_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        time_left_next = time_left_reg;
        repeat_idx_next = repeat_idx_reg;
        active_next = active_reg;
        held_next = held_reg;
        shown_next = shown_reg;
        wr_en = 1'b0;
        accepted = 1'b0;
        do_finish = 1'b0;
        if (acc) begin
            if (req_type_t'(s_tuser[0]) == REQ_COMMAND) begin
                if (count_reg < QCNT_W'(QUEUE_DEPTH)) begin
                    wr_en = 1'b1;
                    accepted = 1'b1;
                    count_next = count_reg + QCNT_W'(1);
                end
            end else if (phase_reg == PH_IDLE) begin
                if (count_reg != '0) begin
                    head_next = (head_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : head_reg + QPTR_W'(1);
                    count_next = count_reg - QCNT_W'(1);
                    if (rd_data_reg.persistent) begin
                        held_next = rd_data_reg.color;
                        do_finish = 1'b1;
                    end else begin
                        active_next = rd_data_reg;
                        repeat_idx_next = '0;
                        phase_next = PH_INIT;
                        shown_next = '0;
                        time_left_next = initial_off_reg;
                    end
                end
            end else if (time_left_reg > 16'd1) begin
                time_left_next = time_left_reg - 16'd1;
            end else begin
                unique case (phase_reg)
                    PH_INIT: begin
                        if (active_reg.repeat_count == '0) begin
                            do_finish = 1'b1;
                        end else begin
                            phase_next = PH_ON;
                            shown_next = active_reg.color;
                            time_left_next = active_reg.on_time_ms;
                        end
                    end
                    PH_ON, PH_OFF: begin
                        if (phase_reg == PH_ON && active_reg.pattern_len[1]) begin
                            phase_next = PH_OFF;
                            shown_next = '0;
                            time_left_next = active_reg.off_time_ms;
                        end else begin
                            repeat_idx_next = repeat_inc;
                            if (repeat_inc < active_reg.repeat_count && repeat_inc != '0) begin
                                phase_next = PH_GAP;
                                shown_next = '0;
                                time_left_next = repeat_gap_reg;
                            end else begin
                                do_finish = 1'b1;
                            end
                        end
                    end
                    PH_GAP: begin
                        phase_next = PH_ON;
                        shown_next = active_reg.color;
                        time_left_next = active_reg.on_time_ms;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                        time_left_next = '0;
                    end
                endcase
            end
        end
        if (do_finish) begin
            shown_next = held_next;
            if (interval_reg != '0) begin
                phase_next = PH_INTERVAL;
                time_left_next = interval_reg;
            end else begin
                phase_next = PH_IDLE;
                time_left_next = '0;
            end
        end
        item_done = do_finish;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            count_reg <= '0;
            phase_reg <= PH_IDLE;
            time_left_reg <= '0;
            repeat_idx_reg <= '0;
            active_reg <= '0;
            held_reg <= '0;
            shown_reg <= '0;
        end else begin
            head_reg <= head_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            time_left_reg <= time_left_next;
            repeat_idx_reg <= repeat_idx_next;
            active_reg <= active_next;
            held_reg <= held_next;
            shown_reg <= shown_next;
        end
    end

    always_comb begin
        result = '0;
        result.led = shown_next;
        result.accepted = accepted;
        result.item_done = item_done;
        result.busy_res = (phase_next != PH_IDLE);
    end

    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg <= 1'b1;
                out_data_reg <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= acc;
                out_data_reg <= result;
            end
        end else if (acc) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held while output register empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> time_left_reg == '0)
        else $error("idle sequencer with a running timer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg != head_next) |-> (count_next == count_reg - QCNT_W'(1)))
        else $error("head advanced without consuming a queued command");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && count_reg == QCNT_W'(QUEUE_DEPTH)) |=> count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("full queue overflowed");

endmodule
